FILE: hdl/nbr_lru_pkg.sv
// Shared constants and word layouts of the neighbor table with least-recently-heard eviction.
`default_nettype none

package nbr_lru_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int KEY_BYTES   = 32;

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_W  = 256;
   localparam int LEN_W  = 6;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam logic OP_NOTE = 1'b0;
   localparam logic OP_FIND = 1'b1;

   // Input word, first field in the lowest bits.
   typedef struct packed {
      logic [1:0]        pad;
      logic [31:0]       time_now;
      logic [7:0]        hop_count;
      logic signed [7:0] snr_quarter_db;
      logic [7:0]        adv_kind;
      logic [LEN_W-1:0]  prefix_len;
      logic [63:0]       key_word3;
      logic [63:0]       key_word2;
      logic [63:0]       key_word1;
      logic [63:0]       key_word0;
   } req_data_type;

   // Result word, first field in the lowest bits.
   typedef struct packed {
      logic [31:0]       hear_count;
      logic [31:0]       heard_time;
      logic [7:0]        hops_out;
      logic signed [7:0] snr_out;
      logic [7:0]        adv_kind_out;
      logic [7:0]        slot;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);
   localparam int RSP_USER_W = 3;

   // One table row apart from the key.
   typedef struct packed {
      logic [31:0]       count;
      logic [31:0]       heard;
      logic [7:0]        hops;
      logic signed [7:0] snr;
      logic [7:0]        kind;
   } entry_type;

endpackage

`default_nettype wire

FILE: hdl/nbr_lru_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module nbr_lru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/neighbour_table_lru_evict.sv
// Neighbor table top level: key match scan, eviction scan and entry update.
//
// Input words arrive on req_; req_tuser selects note (update) or find (prefix
// lookup). Every word accepted gives exactly one result word on rsp_.
// The table rows live in two RAMs (keys and entry fields) that share one read
// port address, so the sequencer visits one slot per cycle.
// A find or a note scans only the filled slots, where used is the number of
// filled slots; a note that misses on a full table adds an eviction pass
// over all TABLE_SLOTS slots. A find with an invalid prefix length skips
// the scan and answers with a miss.
// req_tready is high only while the sequencer is idle; one word is in work
// at a time.
// The result sits in an output register: when the receiver stalls, the block
// still takes and works on the next word, and holds its result until the
// register frees up.
// Reset empties the table (fill count to zero) and drops any pending result;
// the RAM contents are not cleared, since only filled slots are read.
`default_nettype none

module neighbour_table_lru_evict
   import nbr_lru_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // key_word0, key_word1, key_word2, key_word3, prefix_len, adv_kind,
   // snr_quarter_db, hop_count, time_now, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // slot, adv_kind_out, snr_out, hops_out, heard_time, hear_count
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // found, is_new_entry, evicted
   output logic      [RSP_USER_W-1:0] rsp_tuser
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVICT,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic       evicted;
      logic       is_new;
      logic       found;
      logic [7:0] slot;
      entry_type  ent;
   } res_type;

   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  mask_ff, mask_in;
   logic [7:0]        kind_ff, kind_in;
   logic signed [7:0] snr_ff, snr_in;
   logic [7:0]        hops_ff, hops_in;
   logic [31:0]       time_ff, time_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              isnew_ff, isnew_in;
   logic              evict_ff, evict_in;
   logic [31:0]       base_ff, base_in;
   logic [31:0]       min_time_ff, min_time_in;
   logic [SLOT_W-1:0] min_idx_ff, min_idx_in;
   res_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_ff, rsp_in;

   req_data_type      req_word;
   logic [LEN_W-1:0]  len_sel;
   logic              len_bad;
   logic [CNT_W-1:0]  scan_limit;
   logic              issue_go;
   logic              key_hit;
   logic [31:0]       count_next;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic [KEY_W-1:0]  key_rd;
   logic [$bits(entry_type)-1:0] ent_rd_bits;
   entry_type         ent_rd;
   entry_type         ent_wr;
   logic              ent_wr_en;
   logic              key_wr_en;

   assign req_word = req_data_type'(req_tdata);
   assign len_sel  = (req_tuser[0] == OP_FIND) ? req_word.prefix_len : LEN_W'(KEY_BYTES);
   assign len_bad  = (req_tuser[0] == OP_FIND) &&
                     ((len_sel == '0) || (len_sel > LEN_W'(KEY_BYTES)));

   assign scan_limit = (state_ff == ST_EVICT) ? CNT_W'(TABLE_SLOTS) : used_ff;
   assign issue_go   = ((state_ff == ST_SCAN) || (state_ff == ST_EVICT)) &&
                       (issue_ff < scan_limit);
   assign rd_en      = issue_go;
   assign rd_addr    = issue_ff[SLOT_W-1:0];

   assign ent_rd     = entry_type'(ent_rd_bits);
   assign key_hit    = ((key_rd ^ key_ff) & mask_ff) == '0;
   assign count_next = (base_ff == COUNT_MAX) ? base_ff : base_ff + 32'd1;

   assign ent_wr    = '{count: count_next, heard: time_ff, hops: hops_ff,
                        snr: snr_ff, kind: kind_ff};
   assign ent_wr_en = (state_ff == ST_COMMIT);
   assign key_wr_en = (state_ff == ST_COMMIT) && isnew_ff;

   nbr_lru_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (slot_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   nbr_lru_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ent_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ent_rd_bits)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      mask_in      = mask_ff;
      kind_in      = kind_ff;
      snr_in       = snr_ff;
      hops_in      = hops_ff;
      time_in      = time_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      slot_in      = slot_ff;
      isnew_in     = isnew_ff;
      evict_in     = evict_ff;
      base_in      = base_ff;
      min_time_in  = min_time_ff;
      min_idx_in   = min_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               key_in   = {req_word.key_word0, req_word.key_word1,
                           req_word.key_word2, req_word.key_word3};
               kind_in  = req_word.adv_kind;
               snr_in   = req_word.snr_quarter_db;
               hops_in  = req_word.hop_count;
               time_in  = req_word.time_now;
               issue_in = '0;
               pend_in  = 1'b0;
               // byte 0 sits in the top bits; keep the first len_sel bytes
               for (int i = 0; i < KEY_W / 8; i++) begin
                  mask_in[KEY_W-1-8*i -: 8] = {8{LEN_W'(i) < len_sel}};
               end
               if (len_bad) begin
                  res_in   = '0;
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            pend_in     = issue_go;
            pend_idx_in = issue_ff[SLOT_W-1:0];
            if (issue_go) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (pend_ff && key_hit) begin
               pend_in = 1'b0;
               if (op_ff == OP_FIND) begin
                  res_in   = '{evicted: 1'b0, is_new: 1'b0, found: 1'b1,
                               slot: 8'(pend_idx_ff), ent: ent_rd};
                  state_in = ST_RESULT;
               end else begin
                  slot_in  = pend_idx_ff;
                  isnew_in = 1'b0;
                  evict_in = 1'b0;
                  base_in  = ent_rd.count;
                  state_in = ST_COMMIT;
               end
            end else if (!pend_ff && !issue_go) begin
               // scan exhausted without a match
               if (op_ff == OP_FIND) begin
                  res_in   = '0;
                  state_in = ST_RESULT;
               end else if (used_ff < CNT_W'(TABLE_SLOTS)) begin
                  slot_in  = used_ff[SLOT_W-1:0];
                  used_in  = used_ff + CNT_W'(1);
                  isnew_in = 1'b1;
                  evict_in = 1'b0;
                  base_in  = '0;
                  state_in = ST_COMMIT;
               end else begin
                  issue_in = '0;
                  pend_in  = 1'b0;
                  state_in = ST_EVICT;
               end
            end
         end

         ST_EVICT: begin
            pend_in     = issue_go;
            pend_idx_in = issue_ff[SLOT_W-1:0];
            if (issue_go) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            // strict less keeps the lowest index on ties
            if (pend_ff && ((pend_idx_ff == '0) || (ent_rd.heard < min_time_ff))) begin
               min_time_in = ent_rd.heard;
               min_idx_in  = pend_idx_ff;
            end
            if (!pend_ff && !issue_go) begin
               slot_in  = min_idx_ff;
               isnew_in = 1'b1;
               evict_in = 1'b1;
               base_in  = '0;
               state_in = ST_COMMIT;
            end
         end

         ST_COMMIT: begin
            res_in   = '{evicted: evict_ff, is_new: isnew_ff, found: 1'b1,
                         slot: 8'(slot_ff), ent: ent_wr};
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      mask_ff     <= mask_in;
      kind_ff     <= kind_in;
      snr_ff      <= snr_in;
      hops_ff     <= hops_in;
      time_ff     <= time_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      isnew_ff    <= isnew_in;
      evict_ff    <= evict_in;
      base_ff     <= base_in;
      min_time_ff <= min_time_in;
      min_idx_ff  <= min_idx_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_type'{hear_count: rsp_ff.ent.count,
                                      heard_time: rsp_ff.ent.heard,
                                      hops_out: rsp_ff.ent.hops,
                                      snr_out: rsp_ff.ent.snr,
                                      adv_kind_out: rsp_ff.ent.kind,
                                      slot: rsp_ff.slot};
   assign rsp_tuser  = {rsp_ff.evicted, rsp_ff.is_new, rsp_ff.found};

endmodule

`default_nettype wire

FILE: hdl/nbr_lru_chk.sv
// Port-level checker for the neighbor table, bound to the top level.
`default_nettype none

module nbr_lru_chk
   import nbr_lru_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [0:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one word in work at a time: no accept right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while previous word in work");

   // a miss carries an all-zero payload and no flags
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && rsp_tuser == '0)
      else $error("miss result with nonzero payload");

   // eviction only happens when a new entry is created, which is always found
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2] || rsp_tuser[1]) |-> rsp_tuser[1] && rsp_tuser[0])
      else $error("inconsistent result flags");

endmodule

bind neighbour_table_lru_evict nbr_lru_chk u_nbr_lru_chk (.*);

`default_nettype wire
